// ===== sv/pidhc_pkg.sv =====
// Shared widths, register indexes, reset values and the configuration struct.
package pidhc_pkg;

  localparam int TEMP_W     = 16;
  localparam int MS_W       = 16;
  localparam int TGT_W      = 14;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int ILIM_W     = 31;
  localparam int ERR_W      = 17;
  localparam int DERR_W     = 18;
  localparam int INTG_W     = 32;
  localparam int ISUM_W     = 34;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 16;
  localparam int MUL_P_W    = 50;
  localparam int DIV_N_W    = 36;
  localparam int DIV_D_W    = 16;
  localparam int TERM_W     = 37;
  localparam int SUM_W      = 39;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Integral term divides by 256000 = 2^11 * 125.
  localparam int ITERM_SHIFT = 11;
  localparam logic [DIV_D_W-1:0] ITERM_DIV = 16'd125;
  // Derivative term: times 1000, then divide by 256 * ms.
  localparam int DTERM_SHIFT = 8;
  localparam logic [MUL_B_W-1:0] DTERM_SCALE = 16'd1000;
  localparam int PTERM_SHIFT = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_BAND     = 3'd6;

  localparam logic [TGT_W-1:0]  RST_TARGET_TEMP    = 14'd6400;
  localparam logic [GAIN_W-1:0] RST_KP_GAIN        = 16'd512;
  localparam logic [GAIN_W-1:0] RST_KI_GAIN        = 16'd26;
  localparam logic [GAIN_W-1:0] RST_KD_GAIN        = 16'd128;
  localparam logic [LIM_W-1:0]  RST_OUT_LIMIT      = 15'd25600;
  localparam logic [ILIM_W-1:0] RST_INTEGRAL_LIMIT = 31'd256000000;
  localparam logic [LIM_W-1:0]  RST_RELAY_BAND     = 15'd2560;

  typedef struct packed {
    logic [TGT_W-1:0]  target_temp;
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [LIM_W-1:0]  out_limit;
    logic [ILIM_W-1:0] integral_limit;
    logic [LIM_W-1:0]  relay_band;
  } cfg_t;

endpackage

// ===== sv/pidhc_regs.sv =====
// Configuration register file written through the plain write port.
module pidhc_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pidhc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pidhc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output pidhc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp    <= pidhc_pkg::RST_TARGET_TEMP;
      cfg.kp_gain        <= pidhc_pkg::RST_KP_GAIN;
      cfg.ki_gain        <= pidhc_pkg::RST_KI_GAIN;
      cfg.kd_gain        <= pidhc_pkg::RST_KD_GAIN;
      cfg.out_limit      <= pidhc_pkg::RST_OUT_LIMIT;
      cfg.integral_limit <= pidhc_pkg::RST_INTEGRAL_LIMIT;
      cfg.relay_band     <= pidhc_pkg::RST_RELAY_BAND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pidhc_pkg::REG_TARGET_TEMP:    cfg.target_temp    <= cfg_data[pidhc_pkg::TGT_W-1:0];
        pidhc_pkg::REG_KP_GAIN:        cfg.kp_gain        <= cfg_data[pidhc_pkg::GAIN_W-1:0];
        pidhc_pkg::REG_KI_GAIN:        cfg.ki_gain        <= cfg_data[pidhc_pkg::GAIN_W-1:0];
        pidhc_pkg::REG_KD_GAIN:        cfg.kd_gain        <= cfg_data[pidhc_pkg::GAIN_W-1:0];
        pidhc_pkg::REG_OUT_LIMIT:      cfg.out_limit      <= cfg_data[pidhc_pkg::LIM_W-1:0];
        pidhc_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[pidhc_pkg::ILIM_W-1:0];
        pidhc_pkg::REG_RELAY_BAND:     cfg.relay_band     <= cfg_data[pidhc_pkg::LIM_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

// ===== sv/pidhc_mul.sv =====
// Shared signed-by-unsigned multiplier with a registered product.
module pidhc_mul (
  input  logic                                  clk,
  input  logic signed [pidhc_pkg::MUL_A_W-1:0]  a,
  input  logic        [pidhc_pkg::MUL_B_W-1:0]  b,
  output logic signed [pidhc_pkg::MUL_P_W-1:0]  prod
);

  logic signed [pidhc_pkg::MUL_P_W:0] full;

  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod <= full[pidhc_pkg::MUL_P_W-1:0];
  end

endmodule

// ===== sv/pidhc_div.sv =====
// Shared unsigned restoring divider, two quotient bits per cycle.
module pidhc_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [pidhc_pkg::DIV_N_W-1:0]        dividend,
  input  logic [pidhc_pkg::DIV_D_W-1:0]        divisor,
  output logic                                 busy,
  output logic [pidhc_pkg::DIV_N_W-1:0]        quot
);

  localparam int N     = pidhc_pkg::DIV_N_W;
  localparam int D     = pidhc_pkg::DIV_D_W;
  localparam int STEPS = N / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [D-1:0]     rem;
  logic [D-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic [D-1:0]     rem_next;
  logic [N-1:0]     quot_next;
  logic [D:0]       trial;

  always_comb begin
    rem_next  = rem;
    quot_next = quot;
    trial     = '0;
    for (int k = 0; k < 2; k++) begin
      trial     = {rem_next, quot_next[N-1]};
      quot_next = {quot_next[N-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial        = trial - {1'b0, dvs};
        quot_next[0] = 1'b1;
      end
      rem_next = trial[D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (cnt != '0) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  assign busy = (cnt != '0);

endmodule

// ===== sv/pid_heat_cool_controller.sv =====
// PID heat/cool controller top level: sequencer, datapath and output register.
//
// Usage:
//   Configuration: pulse cfg_we with cfg_index (0..6) and cfg_data while the
//   block is idle; indexes above 6 are ignored. Registers take effect on the
//   next sample.
//   Input channel: a sample (measured_temp, elapsed_ms) is taken when in_valid
//   is high and in_stall is low. in_stall stays high while a sample is being
//   worked on.
//   Output channel: drive, heat_on and cool_on are held in an output register
//   with out_valid; the transaction completes when out_stall is low.
//   Timing: a sample with elapsed_ms of zero goes straight to the output step
//   and yields a zero result. Any other sample runs five passes through the
//   shared multiplier and two passes through the shared divider before its
//   result reaches out_valid. The next sample is accepted as soon as the
//   result has been moved into the output register, even if the receiver
//   still stalls it. A stalled output holds the sequencer at its final step
//   until the register frees up.
//   Reset: synchronous, active high; restores register defaults, clears the
//   error integral and the prior error, and empties the output register.
module pid_heat_cool_controller (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [pidhc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidhc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pidhc_pkg::TEMP_W-1:0]    measured_temp,
  input  logic        [pidhc_pkg::MS_W-1:0]      elapsed_ms,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pidhc_pkg::TEMP_W-1:0]    drive,
  output logic                                   heat_on,
  output logic                                   cool_on
);

  typedef enum logic [3:0] {
    S_IDLE, S_EMS, S_SUM, S_CLMP, S_KDDE, S_KIACC, S_SCALE,
    S_DIVI_GO, S_DIVI_WAIT, S_DIVD_GO, S_DIVD_WAIT,
    S_ADD1, S_ADD2, S_LIMIT, S_OUT
  } state_t;

  localparam int P_W = pidhc_pkg::MUL_P_W;
  localparam int A_W = pidhc_pkg::MUL_A_W;
  localparam int T_W = pidhc_pkg::TERM_W;
  localparam int S_W = pidhc_pkg::SUM_W;
  localparam int N_W = pidhc_pkg::DIV_N_W;

  state_t state;
  pidhc_pkg::cfg_t cfg;

  // architectural state
  logic signed [pidhc_pkg::INTG_W-1:0] err_int;
  logic signed [pidhc_pkg::ERR_W-1:0]  prior;

  // per-sample working registers
  logic signed [pidhc_pkg::ERR_W-1:0]  e;
  logic signed [pidhc_pkg::DERR_W-1:0] de;
  logic        [pidhc_pkg::MS_W-1:0]   ms_r;
  logic                                skip;
  logic signed [pidhc_pkg::ISUM_W-1:0] isum;
  logic signed [pidhc_pkg::INTG_W-1:0] acc;
  logic signed [A_W-1:0]               kdde;
  logic signed [T_W-1:0]               p_term;
  logic signed [T_W-1:0]               i_term;
  logic signed [T_W-1:0]               d_term;
  logic                                i_neg;
  logic                                d_neg;
  logic [N_W-1:0]                      i_num;
  logic [N_W-1:0]                      d_num;
  logic signed [S_W-1:0]               pi_sum;
  logic signed [S_W-1:0]               tot;
  logic signed [pidhc_pkg::TEMP_W-1:0] drive_val;

  // shared units
  logic signed [A_W-1:0]                 mul_a;
  logic        [pidhc_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [P_W-1:0]                 prod;
  logic                                  div_start;
  logic [N_W-1:0]                        div_n;
  logic [pidhc_pkg::DIV_D_W-1:0]         div_d;
  logic                                  div_busy;
  logic [N_W-1:0]                        div_q;

  // helpers
  logic signed [pidhc_pkg::ERR_W-1:0]  e_new;
  logic        [P_W-1:0]               prod_mag;
  logic signed [pidhc_pkg::ISUM_W-1:0] p_biased;
  logic signed [pidhc_pkg::ISUM_W-1:0] p_sh;
  logic signed [pidhc_pkg::ISUM_W-1:0] ilim_s;
  logic signed [pidhc_pkg::ISUM_W-1:0] ilim_neg;
  logic signed [S_W-1:0]               olim_s;
  logic signed [S_W-1:0]               olim_neg;
  logic signed [T_W-1:0]               q_pos;
  logic signed [pidhc_pkg::LIM_W+1:0]  dv17;
  logic signed [pidhc_pkg::LIM_W+1:0]  rb17;
  logic signed [pidhc_pkg::LIM_W+1:0]  ol17;
  logic signed [pidhc_pkg::INTG_W-1:0] il32;

  pidhc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidhc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pidhc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quot     (div_q)
  );

  assign in_stall = (state != S_IDLE);

  assign e_new = $signed({3'b000, cfg.target_temp}) -
                 $signed({measured_temp[pidhc_pkg::TEMP_W-1], measured_temp});

  assign prod_mag = prod[P_W-1] ? P_W'(-prod) : P_W'(prod);
  // truncate toward zero: bias negatives before the arithmetic shift
  assign p_biased = prod[pidhc_pkg::ISUM_W-1:0] +
                    (prod[P_W-1] ? pidhc_pkg::ISUM_W'(255) : pidhc_pkg::ISUM_W'(0));
  assign p_sh     = p_biased >>> pidhc_pkg::PTERM_SHIFT;

  assign ilim_s   = $signed({3'b000, cfg.integral_limit});
  assign ilim_neg = -ilim_s;
  assign olim_s   = $signed({{(S_W - pidhc_pkg::LIM_W){1'b0}}, cfg.out_limit});
  assign olim_neg = -olim_s;
  assign q_pos    = $signed({1'b0, div_q});

  assign dv17 = {drive_val[pidhc_pkg::TEMP_W-1], drive_val};
  assign rb17 = $signed({2'b00, cfg.relay_band});
  assign ol17 = $signed({2'b00, cfg.out_limit});
  assign il32 = $signed({1'b0, cfg.integral_limit});

  always_comb begin
    unique case (state)
      S_SUM: begin
        mul_a = A_W'(e);
        mul_b = cfg.kp_gain;
      end
      S_CLMP: begin
        mul_a = A_W'(de);
        mul_b = cfg.kd_gain;
      end
      S_KDDE: begin
        mul_a = A_W'(acc);
        mul_b = cfg.ki_gain;
      end
      S_KIACC: begin
        mul_a = kdde;
        mul_b = pidhc_pkg::DTERM_SCALE;
      end
      default: begin
        mul_a = A_W'(e);
        mul_b = ms_r;
      end
    endcase
  end

  assign div_start = (state == S_DIVI_GO) || (state == S_DIVD_GO);
  assign div_n     = (state == S_DIVD_GO) ? d_num : i_num;
  assign div_d     = (state == S_DIVD_GO) ? ms_r : pidhc_pkg::ITERM_DIV;

  // sequencer with its control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      err_int   <= '0;
      prior     <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (elapsed_ms == '0) ? S_OUT : S_EMS;
          end
        end
        S_EMS:       state <= S_SUM;
        S_SUM:       state <= S_CLMP;
        S_CLMP:      state <= S_KDDE;
        S_KDDE:      state <= S_KIACC;
        S_KIACC:     state <= S_SCALE;
        S_SCALE:     state <= S_DIVI_GO;
        S_DIVI_GO:   state <= S_DIVI_WAIT;
        S_DIVI_WAIT: if (!div_busy) state <= S_DIVD_GO;
        S_DIVD_GO:   state <= S_DIVD_WAIT;
        S_DIVD_WAIT: if (!div_busy) state <= S_ADD1;
        S_ADD1:      state <= S_ADD2;
        S_ADD2:      state <= S_LIMIT;
        S_LIMIT: begin
          err_int <= acc;
          prior   <= e;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          e         <= e_new;
          ms_r      <= elapsed_ms;
          skip      <= (elapsed_ms == '0);
          drive_val <= '0;
        end
      end
      S_EMS: de <= pidhc_pkg::DERR_W'(e) - pidhc_pkg::DERR_W'(prior);
      S_SUM: isum <= pidhc_pkg::ISUM_W'(err_int) + prod[pidhc_pkg::ISUM_W-1:0];
      S_CLMP: begin
        priority if (isum > ilim_s) acc <= ilim_s[pidhc_pkg::INTG_W-1:0];
        else if (isum < ilim_neg)   acc <= ilim_neg[pidhc_pkg::INTG_W-1:0];
        else                        acc <= isum[pidhc_pkg::INTG_W-1:0];
        p_term <= {{(T_W - pidhc_pkg::ISUM_W){p_sh[pidhc_pkg::ISUM_W-1]}}, p_sh};
      end
      S_KDDE: kdde <= prod[A_W-1:0];
      S_KIACC: begin
        i_neg <= prod[P_W-1];
        i_num <= prod_mag[pidhc_pkg::ITERM_SHIFT +: N_W];
      end
      S_SCALE: begin
        d_neg <= prod[P_W-1];
        d_num <= prod_mag[pidhc_pkg::DTERM_SHIFT +: N_W];
      end
      S_DIVI_WAIT: if (!div_busy) i_term <= i_neg ? -q_pos : q_pos;
      S_DIVD_WAIT: if (!div_busy) d_term <= d_neg ? -q_pos : q_pos;
      S_ADD1: pi_sum <= S_W'(p_term) + S_W'(i_term);
      S_ADD2: tot <= pi_sum + S_W'(d_term);
      S_LIMIT: begin
        priority if (tot > olim_s) drive_val <= olim_s[pidhc_pkg::TEMP_W-1:0];
        else if (tot < olim_neg)   drive_val <= olim_neg[pidhc_pkg::TEMP_W-1:0];
        else                       drive_val <= tot[pidhc_pkg::TEMP_W-1:0];
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          drive   <= drive_val;
          heat_on <= (dv17 > rb17);
          cool_on <= (dv17 < -rb17);
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_relay_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(heat_on && cool_on))
    else $error("heat and cool both on");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && skip) |-> (drive_val == '0))
    else $error("skipped sample with nonzero drive");

  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !skip) |-> (dv17 <= ol17 && dv17 >= -ol17))
    else $error("drive outside out_limit");

  a_integral_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !skip) |-> (err_int <= il32 && err_int >= -il32))
    else $error("error integral outside its limit");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider busy while idle");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the PID heat/cool controller: directed and random samples vs. a predictor.
`timescale 1ns / 1ps

module tb_top;
  import pidhc_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_SAMPLES = 148;
  localparam int MAX_REPORTS   = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PICK_ZERO = 0;
  localparam int PICK_TOP  = 1;
  localparam int PICK_WORD = 2;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic        [MS_W-1:0]   ms;
  } sample_t;

  typedef struct {
    logic signed [TEMP_W-1:0] drive;
    logic                     heat;
    logic                     cool;
  } drive_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic signed [TEMP_W-1:0]     measured_temp = '0;
  logic [MS_W-1:0]              elapsed_ms = '0;
  logic                         out_stall = 1'b0;
  wire                          in_stall;
  wire                          out_valid;
  wire signed [TEMP_W-1:0]      drive;
  wire                          heat_on;
  wire                          cool_on;

  // Predictor copy of the registers and the loop state
  cfg_t                         ctrl_cfg;
  logic signed [INTG_W-1:0]     err_integral;
  logic signed [ERR_W-1:0]      last_error;

  sample_t                      pending_samples[$];
  drive_result_t                expected_drives[$];

  int  samples_queued = 0;
  int  samples_taken = 0;
  int  results_checked = 0;
  int  zero_ms_seen = 0;
  int  heat_seen = 0;
  int  cool_seen = 0;
  int  reg_writes = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  idle_odds = 4;
  int  send_gap = 0;
  int  stall_gap = 0;
  bit  calm = 1'b0;
  logic in_fire = 1'b0;

  pid_heat_cool_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .measured_temp (measured_temp),
    .elapsed_ms    (elapsed_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .heat_on       (heat_on),
    .cool_on       (cool_on)
  );

  always #10 clk = ~clk;

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance the controller by one sample and return the drive it should produce
  function automatic drive_result_t pid_step(input sample_t s);
    drive_result_t r;
    longint        ms;
    longint        e;
    longint        acc;
    longint        p;
    longint        it;
    longint        d;
    longint        total;
    r.drive = '0;
    r.heat  = 1'b0;
    r.cool  = 1'b0;
    // Zero elapsed time: zero drive, state untouched
    if (s.ms == '0) return r;
    ms    = longint'(s.ms);
    e     = longint'(ctrl_cfg.target_temp) - longint'(s.temp);
    acc   = clamp_sym(longint'(err_integral) + e * ms, longint'(ctrl_cfg.integral_limit));
    p     = (longint'(ctrl_cfg.kp_gain) * e) / 256;
    it    = (longint'(ctrl_cfg.ki_gain) * acc) / 256000;
    d     = (longint'(ctrl_cfg.kd_gain) * (e - longint'(last_error)) * 1000) / (256 * ms);
    total = clamp_sym(p + it + d, longint'(ctrl_cfg.out_limit));
    err_integral = acc[INTG_W-1:0];
    last_error   = e[ERR_W-1:0];
    r.drive = total[TEMP_W-1:0];
    r.heat  = total > longint'(ctrl_cfg.relay_band);
    r.cool  = total < -longint'(ctrl_cfg.relay_band);
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(input logic [CFG_IDX_W-1:0] idx,
                                                      input int pick);
    int                    w;
    logic [CFG_DATA_W-1:0] usual;
    case (idx)
      REG_TARGET_TEMP: begin w = TGT_W;  usual = 12800; end
      REG_KP_GAIN: begin w = GAIN_W; usual = 2048; end
      REG_KI_GAIN: begin w = GAIN_W; usual = 512; end
      REG_KD_GAIN: begin w = GAIN_W; usual = 2048; end
      REG_OUT_LIMIT: begin w = LIM_W;  usual = 32767; end
      REG_INTEGRAL_LIMIT: begin w = ILIM_W; usual = 300000000; end
      default: begin w = LIM_W;  usual = 4096; end
    endcase
    case (pick)
      PICK_ZERO: return '0;
      PICK_TOP: return {CFG_DATA_W{1'b1}} >> (CFG_DATA_W - w);
      // Bits above the register width must be dropped by the block
      PICK_WORD: return $urandom;
      default: return $urandom_range(0, usual);
    endcase
  endfunction

  function automatic sample_t make_sample();
    sample_t s;
    int      t;
    case ($urandom_range(0, 9))
      0: s.temp = $urandom_range(0, 16'hFFFF);
      1: s.temp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: begin
        t = int'($urandom_range(0, 2048)) - 1024 + int'(ctrl_cfg.target_temp);
        s.temp = t;
      end
    endcase
    case ($urandom_range(0, 9))
      0: s.ms = '0;
      1: s.ms = 16'hFFFF;
      2: s.ms = $urandom_range(0, 16'hFFFF);
      3, 4: s.ms = $urandom_range(1, 16);
      default: s.ms = $urandom_range(100, 5000);
    endcase
    return s;
  endfunction

  task automatic queue_sample(input logic signed [TEMP_W-1:0] temp, input logic [MS_W-1:0] ms);
    sample_t s;
    s.temp = temp;
    s.ms   = ms;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    reg_writes++;
    case (idx)
      REG_TARGET_TEMP: ctrl_cfg.target_temp = data[TGT_W-1:0];
      REG_KP_GAIN: ctrl_cfg.kp_gain = data[GAIN_W-1:0];
      REG_KI_GAIN: ctrl_cfg.ki_gain = data[GAIN_W-1:0];
      REG_KD_GAIN: ctrl_cfg.kd_gain = data[GAIN_W-1:0];
      REG_OUT_LIMIT: ctrl_cfg.out_limit = data[LIM_W-1:0];
      REG_INTEGRAL_LIMIT: ctrl_cfg.integral_limit = data[ILIM_W-1:0];
      REG_RELAY_BAND: ctrl_cfg.relay_band = data[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (samples_taken != samples_queued || expected_drives.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("Mismatch at result %0d: %s got %0d, expected %0d",
               results_checked, what, got, want);
  endtask

  // Sample driver: hold a stalled transaction, otherwise idle or present the next one
  always @(negedge clk) begin : feed
    sample_t s;
    if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(1, idle_odds) == 1) begin
        send_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else begin
        s = pending_samples.pop_front();
        measured_temp <= s.temp;
        elapsed_ms    <= s.ms;
        in_valid      <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_gap > 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(1, idle_odds) == 1) begin
      stall_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch
    sample_t       s;
    drive_result_t want;
    in_fire <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      s.temp = measured_temp;
      s.ms   = elapsed_ms;
      expected_drives.push_back(pid_step(s));
      samples_taken++;
      if (elapsed_ms == '0) zero_ms_seen++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_drives.size() == 0) begin
        report_mismatch("result with none pending, drive", longint'(drive), 0);
      end else begin
        want = expected_drives.pop_front();
        if (drive !== want.drive) report_mismatch("drive", longint'(drive), longint'(want.drive));
        if (heat_on !== want.heat) report_mismatch("heat_on", heat_on, want.heat);
        if (cool_on !== want.cool) report_mismatch("cool_on", cool_on, want.cool);
        results_checked++;
        heat_seen += want.heat;
        cool_seen += want.cool;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_drives.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int                   ph;
    logic [CFG_IDX_W-1:0] idx;
    int                   pick;
    ctrl_cfg = '{RST_TARGET_TEMP, RST_KP_GAIN, RST_KI_GAIN, RST_KD_GAIN,
                 RST_OUT_LIMIT, RST_INTEGRAL_LIMIT, RST_RELAY_BAND};
    err_integral = '0;
    last_error   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Reset settings; first sample sees its whole error as a derivative step
    queue_sample(16'd2560, 16'd1000);
    queue_sample(16'd6400, 16'd0);
    queue_sample(16'h8000, 16'd1);
    queue_sample(16'h7FFF, 16'hFFFF);
    queue_sample(16'h8000, 16'hFFFF);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'd6400, 16'd1000);
    queue_sample(16'd6300, 16'd500);
    queue_sample(16'h8000, 16'hFFFF);
    wait_idle();

    // Lowered integral limit clamps the stored integral on the next sample
    write_reg(REG_INTEGRAL_LIMIT, 31'd1000);
    queue_sample(16'd6400, 16'd10);
    queue_sample(16'd6500, 16'd10);
    wait_idle();

    // Setpoint beyond 50 degrees is taken as written
    write_reg(REG_INTEGRAL_LIMIT, '0);
    write_reg(REG_TARGET_TEMP, 31'h3FFF);
    write_reg(REG_UNUSED, '1);
    queue_sample(16'd0, 16'd100);
    wait_idle();

    // Zero band: a drive of exactly zero keeps both relays off
    write_reg(REG_KI_GAIN, '0);
    write_reg(REG_RELAY_BAND, '0);
    queue_sample(16'h3FFF, 16'd50);
    queue_sample(16'h3FFF, 16'd50);
    queue_sample(16'h3FFE, 16'd50);
    wait_idle();

    write_reg(REG_OUT_LIMIT, '0);
    queue_sample(16'h8000, 16'd1);
    wait_idle();

    write_reg(REG_KP_GAIN, 31'hFFFF);
    write_reg(REG_KI_GAIN, 31'hFFFF);
    write_reg(REG_KD_GAIN, 31'hFFFF);
    write_reg(REG_OUT_LIMIT, 31'h7FFF);
    write_reg(REG_INTEGRAL_LIMIT, 31'h7FFFFFFF);
    write_reg(REG_RELAY_BAND, 31'h7FFF);
    queue_sample(16'h8000, 16'd1);
    queue_sample(16'h7FFF, 16'd1);
    queue_sample(16'h8000, 16'hFFFF);
    queue_sample(16'h7FFF, 16'd0);

    // Random phases: first all registers at the top, then all at zero, then mixed
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      for (idx = REG_TARGET_TEMP; idx <= REG_RELAY_BAND; idx++) begin
        pick = (ph == 0) ? PICK_TOP : (ph == 1) ? PICK_ZERO : $urandom_range(0, 7);
        write_reg(idx, reg_value(idx, pick));
      end
      write_reg(REG_UNUSED, $urandom);
      idle_odds = $urandom_range(2, 8);
      calm = (ph == RANDOM_PHASES - 1);
      repeat (PHASE_SAMPLES) begin
        pending_samples.push_back(make_sample());
        samples_queued++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    error_count += expected_drives.size();
    $display("Ran %0d samples (%0d with zero elapsed time) over %0d register writes",
             samples_taken, zero_ms_seen, reg_writes);
    $display("Checked %0d results: %0d with heat on, %0d with cool on, %0d mismatches",
             results_checked, heat_seen, cool_seen, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== pid_heat_cool_controller.f =====
sv/pidhc_pkg.sv
sv/pidhc_regs.sv
sv/pidhc_mul.sv
sv/pidhc_div.sv
sv/pid_heat_cool_controller.sv
tb/tb_top.sv
